FILE: hw/rtl/nairt_pkg.sv
// Shared types and constants of the nearest anchor in radius table.
`default_nettype none

package nairt_pkg;

    // Field widths fixed by the transaction format
    localparam int COORD_BITS  = 24;
    localparam int RADIUS_BITS = COORD_BITS - 1;
    localparam int ID_BITS     = 16;
    localparam int DIST_BITS   = 50;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 5;

    // Action codes
    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [1:0] ACT_QUERY      = 2'd2;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_DONE        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_PRESENT = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NULL_ID     = 3'd4;

    typedef struct packed {
        logic [1:0]                    action;
        logic [ID_BITS-1:0]            anchor_id;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  pos_z;
        logic [RADIUS_BITS-1:0]        snap_radius;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   found;
        logic [ID_BITS-1:0]     best_id;
        logic [DIST_BITS-1:0]   best_dist_sq;
        logic [COUNT_BITS-1:0]  entry_count;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                   req_load;
        logic                   scan_issue;
        logic                   new_write;
        logic                   move_read;
        logic                   move_write;
        logic                   cnt_inc;
        logic                   cnt_dec;
        logic                   out_load;
        logic [STATUS_BITS-1:0] status;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] req_action;
        logic       req_id_null;
        logic       pipe_busy;
        logic       id_hit;
        logic       out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nearest_anchor_in_radius_table.sv
// A transaction is accepted only in the idle state, and the next one waits until the result
// register is loaded; on an empty table the scan is skipped, and a removal also passes through
// the move-read and move-write states. The single table read port scans one entry a cycle
// into a four-stage distance pipe.
// Reset clears the entry count and control state; table contents are not cleared.
`default_nettype none

module nearest_anchor_in_radius_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire nairt_pkg::in_item_t   cmd,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output nairt_pkg::out_item_t       res
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    nairt_pkg::ctl_cmd_t  ctl;
    nairt_pkg::dp_stat_t  stat;
    logic [CNT_W-1:0]     count;
    logic [IDX_W-1:0]     rd_addr;

    // Sequence each transaction
    nairt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .count     (count),
        .stat      (stat),
        .ctl       (ctl),
        .rd_addr   (rd_addr)
    );

    // Table, distance pipeline and result register
    nairt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .count     (count),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/nairt_ctrl.sv
// Controller state machine: sequences scans, table updates and result handoff.
`default_nettype none

module nairt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire logic [CNT_W-1:0]     count,
    input  wire nairt_pkg::dp_stat_t  stat,
    output nairt_pkg::ctl_cmd_t       ctl,
    output logic [IDX_W-1:0]          rd_addr
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_DRAIN   = 6'b000100,
        S_MOVE_RD = 6'b001000,
        S_MOVE_WR = 6'b010000,
        S_RESULT  = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [nairt_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [CNT_W-1:0]                 last_entry;
    logic                             table_full;

    assign last_entry = count - CNT_W'(1);
    assign table_full = (count == CNT_W'(TABLE_DEPTH));
    assign cmd_ready  = (state_reg == S_IDLE);

    // Next-state and command decode
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        ctl         = '0;
        ctl.status  = status_reg;
        rd_addr     = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.req_load = 1'b1;
                    idx_next     = '0;
                    status_next  = nairt_pkg::ST_DONE;
                    state_next   = (count == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(1) == count)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_RESULT;
                    case (stat.req_action)
                        nairt_pkg::ACT_REGISTER:
                        begin
                            if (stat.req_id_null)
                            begin
                                status_next = nairt_pkg::ST_NULL_ID;
                            end
                            else if (stat.id_hit)
                            begin
                                status_next = nairt_pkg::ST_DUPLICATE;
                            end
                            else if (table_full)
                            begin
                                status_next = nairt_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.new_write = 1'b1;
                                ctl.cnt_inc   = 1'b1;
                            end
                        end
                        nairt_pkg::ACT_UNREGISTER:
                        begin
                            if (stat.req_id_null)
                            begin
                                status_next = nairt_pkg::ST_NULL_ID;
                            end
                            else if (!stat.id_hit)
                            begin
                                status_next = nairt_pkg::ST_NOT_PRESENT;
                            end
                            else
                            begin
                                state_next = S_MOVE_RD;
                            end
                        end
                        default:
                        begin
                            status_next = nairt_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_MOVE_RD:
            begin
                // Fetch the last entry to fill the freed slot
                ctl.move_read = 1'b1;
                rd_addr       = IDX_W'(last_entry);
                state_next    = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                ctl.move_write = 1'b1;
                ctl.cnt_dec    = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            status_reg <= nairt_pkg::ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nairt_dp.sv
// Datapath: anchor table memory, distance pipeline, best tracker and result register.
`default_nettype none

module nairt_dp #(
    parameter int TABLE_DEPTH = 16,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nairt_pkg::in_item_t  cmd,
    input  wire nairt_pkg::ctl_cmd_t  ctl,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output logic [CNT_W-1:0]          count,
    output nairt_pkg::dp_stat_t       stat,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output nairt_pkg::out_item_t      res
);

    localparam int CB       = nairt_pkg::COORD_BITS;
    localparam int RB       = nairt_pkg::RADIUS_BITS;
    localparam int IB       = nairt_pkg::ID_BITS;
    localparam int MAG_BITS = CB + 1;
    localparam int SQ_BITS  = 2 * MAG_BITS;
    localparam int SUM_BITS = SQ_BITS + 2;
    localparam int R2_BITS  = 2 * RB;

    typedef struct packed {
        logic [IB-1:0] id;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] z;
        logic [RB-1:0] radius;
    } entry_t;

    function automatic logic [MAG_BITS-1:0] abs_diff(input logic [CB-1:0] a,
                                                     input logic [CB-1:0] b);
        logic [MAG_BITS-1:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        return d[MAG_BITS-1] ? (~d + MAG_BITS'(1)) : d;
    endfunction

    entry_t                mem [TABLE_DEPTH];
    nairt_pkg::in_item_t   req_reg;
    entry_t                rd_data_reg;
    logic [CNT_W-1:0]      count_reg;

    logic                  s1_valid_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s2_valid_reg;
    logic [MAG_BITS-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic [RB-1:0]         s2_rad_reg;
    logic [IB-1:0]         s2_id_reg;
    logic                  s3_valid_reg;
    logic [SQ_BITS-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [R2_BITS-1:0]    s3_r2_reg;
    logic [IB-1:0]         s3_id_reg;
    logic                  s4_valid_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [R2_BITS-1:0]    s4_r2_reg;
    logic [IB-1:0]         s4_id_reg;

    logic                  best_found_reg;
    logic [IB-1:0]         best_id_reg;
    logic [SUM_BITS-1:0]   best_dist_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;

    logic                  res_valid_reg;
    nairt_pkg::out_item_t  res_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic                  is_query;
    logic                  in_range;
    logic                  closer;

    assign is_query = (req_reg.action == nairt_pkg::ACT_QUERY);

    // Table write port: append a new anchor or move the last one into a hole
    assign mem_we  = ctl.new_write | ctl.move_write;
    assign wr_addr = ctl.new_write ? IDX_W'(count_reg) : hit_idx_reg;
    assign wr_data = ctl.new_write
                   ? entry_t'{req_reg.anchor_id, req_reg.pos_x, req_reg.pos_y,
                              req_reg.pos_z, req_reg.snap_radius}
                   : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Table read port with registered data
    always_ff @(posedge clk)
    begin
        if (ctl.scan_issue || ctl.move_read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Capture the request transaction
    always_ff @(posedge clk)
    begin
        if (ctl.req_load)
        begin
            req_reg <= cmd;
        end
    end

    // Distance pipeline payload: differences, squares, sum
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= rd_addr;
        mag_x_reg  <= abs_diff(req_reg.pos_x, rd_data_reg.x);
        mag_y_reg  <= abs_diff(req_reg.pos_y, rd_data_reg.y);
        mag_z_reg  <= abs_diff(req_reg.pos_z, rd_data_reg.z);
        s2_rad_reg <= rd_data_reg.radius;
        s2_id_reg  <= rd_data_reg.id;
        sq_x_reg   <= mag_x_reg * mag_x_reg;
        sq_y_reg   <= mag_y_reg * mag_y_reg;
        sq_z_reg   <= mag_z_reg * mag_z_reg;
        s3_r2_reg  <= s2_rad_reg * s2_rad_reg;
        s3_id_reg  <= s2_id_reg;
        sum_reg    <= SUM_BITS'(sq_x_reg) + SUM_BITS'(sq_y_reg) + SUM_BITS'(sq_z_reg);
        s4_r2_reg  <= s3_r2_reg;
        s4_id_reg  <= s3_id_reg;
    end

    // Advance pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.scan_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Track the nearest in-range anchor; strict compare keeps the earlier one on a tie
    assign in_range = (sum_reg <= SUM_BITS'(s4_r2_reg));
    assign closer   = !best_found_reg || (sum_reg < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_id_reg    <= '0;
            best_dist_reg  <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
        end
        else if (ctl.req_load)
        begin
            best_found_reg <= 1'b0;
            best_id_reg    <= '0;
            best_dist_reg  <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (s4_valid_reg && is_query && in_range && closer)
            begin
                best_found_reg <= 1'b1;
                best_id_reg    <= s4_id_reg;
                best_dist_reg  <= sum_reg;
            end
            // Record the first entry whose id matches
            if (s1_valid_reg && !hit_reg && (rd_data_reg.id == req_reg.anchor_id))
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= s1_idx_reg;
            end
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Result register: hold the transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_reg.status       <= ctl.status;
            res_reg.found        <= best_found_reg;
            res_reg.best_id      <= best_id_reg;
            res_reg.best_dist_sq <= nairt_pkg::DIST_BITS'(best_dist_reg);
            res_reg.entry_count  <= nairt_pkg::COUNT_BITS'(count_reg);
        end
    end

    assign res_valid        = res_valid_reg;
    assign res              = res_reg;
    assign count            = count_reg;
    assign stat.req_action  = req_reg.action;
    assign stat.req_id_null = (req_reg.anchor_id == '0);
    assign stat.pipe_busy   = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg;
    assign stat.id_hit      = hit_reg;
    assign stat.out_busy    = res_valid_reg & ~res_ready;

endmodule

`default_nettype wire
